[rtl/mktg_pkg.sv]
// Shared types, codes and lookup tables for the Morse keyer tone generator.
package mktg_pkg;

    // Default widths for the tone phase path
    localparam int PHASE_WIDTH_DEF      = 32;
    localparam int TABLE_INDEX_BITS_DEF = 8;

    // Configuration register indexes and reset values
    localparam logic [1:0]  CFG_UNIT_SAMPLES = 2'd0;
    localparam logic [1:0]  CFG_PHASE_STEP   = 2'd1;
    localparam logic [15:0] UNIT_SAMPLES_RST = 16'd2880;
    localparam logic [31:0] PHASE_STEP_RST   = 32'd89478485;

    localparam logic [7:0] SILENCE = 8'd128;

    // Input commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_CHAR  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_BUSY_TICK = 3'd0;
    localparam logic [2:0] ST_IDLE_TICK = 3'd1;
    localparam logic [2:0] ST_START     = 3'd2;
    localparam logic [2:0] ST_CHAR      = 3'd3;
    localparam logic [2:0] ST_IGNORED   = 3'd4;
    localparam logic [2:0] ST_REJECT    = 3'd5;

    localparam logic [7:0] ASCII_SPACE = 8'h20;

    // Keying stages
    typedef enum logic [3:0] {
        STAGE_IDLE   = 4'b0001,
        STAGE_TONE   = 4'b0010,
        STAGE_GAP    = 4'b0100,
        STAGE_SILENT = 4'b1000
    } stage_t;

    // Per-transfer result of the keyer toward the sample path
    typedef struct packed {
        logic       keyed;   // this tick plays tone
        logic [2:0] status;
        logic       busy;    // busy after this transfer
    } keyer_res_t;

    // Decoded character
    typedef struct packed {
        logic       hit;
        logic [2:0] total;
        logic [4:0] pattern;
    } char_info_t;

    // Quarter sine wave, entries 0..64
    localparam logic [7:0] SINE_QUARTER [65] = '{
        8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
        8'd152, 8'd155, 8'd158, 8'd161, 8'd164, 8'd167, 8'd170, 8'd173,
        8'd176, 8'd179, 8'd182, 8'd185, 8'd187, 8'd190, 8'd193, 8'd195,
        8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd210, 8'd213, 8'd215,
        8'd217, 8'd219, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd231,
        8'd233, 8'd235, 8'd236, 8'd238, 8'd240, 8'd241, 8'd242, 8'd244,
        8'd245, 8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251,
        8'd252, 8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
        8'd255
    };

    // Letters A..Z then digits 0..9: element count in 7:5, dash bits in 4:0
    localparam logic [7:0] CODE_TABLE [36] = '{
        {3'd2, 5'd2},  {3'd4, 5'd1},  {3'd4, 5'd5},  {3'd3, 5'd1},  {3'd1, 5'd0},
        {3'd4, 5'd4},  {3'd3, 5'd3},  {3'd4, 5'd0},  {3'd2, 5'd0},  {3'd4, 5'd14},
        {3'd3, 5'd5},  {3'd4, 5'd2},  {3'd2, 5'd3},  {3'd2, 5'd1},  {3'd3, 5'd7},
        {3'd4, 5'd6},  {3'd4, 5'd11}, {3'd3, 5'd2},  {3'd3, 5'd0},  {3'd1, 5'd1},
        {3'd3, 5'd4},  {3'd4, 5'd8},  {3'd3, 5'd6},  {3'd4, 5'd9},  {3'd4, 5'd13},
        {3'd4, 5'd3},
        {3'd5, 5'd31}, {3'd5, 5'd30}, {3'd5, 5'd28}, {3'd5, 5'd24}, {3'd5, 5'd16},
        {3'd5, 5'd0},  {3'd5, 5'd1},  {3'd5, 5'd3},  {3'd5, 5'd7},  {3'd5, 5'd15}
    };

    // Full-wave sine from the quarter table; the downward zero crossing (index 128)
    // and the trough (index 192) are special-cased
    function automatic logic [7:0] sine_lookup(input logic [7:0] i);
        logic [8:0] j;
        logic [7:0] v;
        j = 9'd0;
        if (i <= 8'd64) begin
            v = SINE_QUARTER[i[6:0]];
        end else if (i < 8'd128) begin
            j = 9'd128 - {1'b0, i};
            v = SINE_QUARTER[j[6:0]];
        end else if (i == 8'd128) begin
            v = 8'd127;
        end else if (i < 8'd192) begin
            j = {1'b0, i} - 9'd128;
            v = 8'd255 - SINE_QUARTER[j[6:0]];
        end else if (i == 8'd192) begin
            v = 8'd1;
        end else begin
            j = 9'd256 - {1'b0, i};
            v = 8'd255 - SINE_QUARTER[j[6:0]];
        end
        return v;
    endfunction

    // ASCII letter (either case) or digit to its element code
    function automatic char_info_t char_decode(input logic [7:0] ch);
        char_info_t info;
        logic [7:0] idx;
        logic [7:0] code;
        info = '0;
        idx  = 8'd0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            idx = ch - 8'h41;
            info.hit = 1'b1;
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            idx = ch - 8'h61;
            info.hit = 1'b1;
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            idx = ch - 8'h30 + 8'd26;
            info.hit = 1'b1;
        end
        code = CODE_TABLE[idx[5:0]];
        if (info.hit) begin
            info.total   = code[7:5];
            info.pattern = code[4:0];
        end
        return info;
    endfunction

endpackage

[rtl/mktg_keyer.sv]
// Morse keying sequencer: element, unit and sample counters.
module mktg_keyer (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic [1:0]             command,
    input  logic [7:0]             char_code,
    input  logic [15:0]            unit_samples,
    output mktg_pkg::keyer_res_t   res
);
    import mktg_pkg::*;

    stage_t      stage_reg,    stage_next;
    logic [4:0]  pattern_reg,  pattern_next;
    logic [2:0]  total_reg,    total_next;
    logic [2:0]  position_reg, position_next;
    logic [2:0]  units_reg,    units_next;
    logic [15:0] samples_reg,  samples_next;

    logic [15:0] unit_len;
    logic [2:0]  pos_inc;
    logic [7:0]  pattern_ext;
    char_info_t  info;

    // A unit of zero samples counts as one
    assign unit_len    = (unit_samples == 16'd0) ? 16'd1 : unit_samples;
    assign pos_inc     = position_reg + 3'd1;
    assign pattern_ext = {3'b000, pattern_reg};
    assign info        = char_decode(char_code);

    // Next state and status for one transfer
    always_comb begin
        stage_next    = stage_reg;
        pattern_next  = pattern_reg;
        total_next    = total_reg;
        position_next = position_reg;
        units_next    = units_reg;
        samples_next  = samples_reg;
        res.status    = ST_IGNORED;
        res.keyed     = 1'b0;

        if (accept) begin
            unique case (command)
                CMD_START: begin
                    pattern_next  = 5'd0;
                    total_next    = 3'd0;
                    position_next = 3'd0;
                    stage_next    = STAGE_SILENT;
                    units_next    = 3'd3;
                    samples_next  = unit_len;
                    res.status    = ST_START;
                end
                CMD_CHAR: begin
                    if (stage_reg != STAGE_IDLE) begin
                        res.status = ST_REJECT;
                    end else if (char_code == ASCII_SPACE) begin
                        stage_next   = STAGE_SILENT;
                        units_next   = 3'd6;
                        samples_next = unit_len;
                        res.status   = ST_CHAR;
                    end else if (info.hit) begin
                        pattern_next  = info.pattern;
                        total_next    = info.total;
                        position_next = 3'd0;
                        stage_next    = STAGE_TONE;
                        units_next    = info.pattern[0] ? 3'd3 : 3'd1;
                        samples_next  = unit_len;
                        res.status    = ST_CHAR;
                    end
                end
                CMD_TICK: begin
                    if (stage_reg == STAGE_IDLE) begin
                        res.status = ST_IDLE_TICK;
                    end else begin
                        res.status = ST_BUSY_TICK;
                        res.keyed  = (stage_reg == STAGE_TONE);
                        if (samples_reg > 16'd1) begin
                            samples_next = samples_reg - 16'd1;
                        end else if (units_reg > 3'd1) begin
                            units_next   = units_reg - 3'd1;
                            samples_next = unit_len;
                        end else begin
                            // end of stage
                            priority if (stage_reg == STAGE_TONE) begin
                                stage_next   = STAGE_GAP;
                                units_next   = 3'd1;
                                samples_next = unit_len;
                            end else if (stage_reg == STAGE_GAP) begin
                                position_next = pos_inc;
                                samples_next  = unit_len;
                                if (pos_inc < total_reg) begin
                                    stage_next = STAGE_TONE;
                                    units_next = pattern_ext[pos_inc] ? 3'd3 : 3'd1;
                                end else begin
                                    stage_next = STAGE_SILENT;
                                    units_next = 3'd2;
                                end
                            end else begin
                                stage_next   = STAGE_IDLE;
                                units_next   = 3'd0;
                                samples_next = 16'd0;
                            end
                        end
                    end
                end
                default: begin
                    res.status = ST_IGNORED;
                end
            endcase
        end
        res.busy = (stage_next != STAGE_IDLE);
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg    <= STAGE_IDLE;
            pattern_reg  <= 5'd0;
            total_reg    <= 3'd0;
            position_reg <= 3'd0;
            units_reg    <= 3'd0;
            samples_reg  <= 16'd0;
        end else begin
            stage_reg    <= stage_next;
            pattern_reg  <= pattern_next;
            total_reg    <= total_next;
            position_reg <= position_next;
            units_reg    <= units_next;
            samples_reg  <= samples_next;
        end
    end

`ifndef ASSERT_OFF
    // an active stage always has time left in it
    a_active_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_reg != STAGE_IDLE) |-> (units_reg != 3'd0 && samples_reg != 16'd0))
        else $error("active stage with empty counters");
    // idle leaves the counters cleared
    a_idle_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_reg == STAGE_IDLE) |-> (units_reg == 3'd0 && samples_reg == 16'd0))
        else $error("idle with counters set");
    // tone only for an element inside the character
    a_tone_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_reg == STAGE_TONE) |-> (position_reg < total_reg))
        else $error("tone past last element");
`endif

endmodule

[rtl/morse_keyer_tone_generator.sv]
// Top level: Morse keyer with phase-accumulator sine tone, one sample per tick.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  s_      | in        | s_valid / s_ready   | s_command, s_char_code
//  m_      | out       | m_valid / m_ready   | m_sample, m_status, m_busy_res
//  cfg_    | in        | cfg_wr_en           | cfg_wr_index, cfg_wr_data
//
// One item per cycle when not stalled; the output register captures its result
// at the transfer. The keyer counters and the phase add plus sine lookup sit
// between the input port and that register. s_ready holds while the output
// register is empty or taken in the same cycle, so stalls on m_ready back up to
// s_ready. Reset (synchronous, aresetn low) clears the keyer to idle, the phase
// to zero, the registers to their defaults and the output register to empty.
module morse_keyer_tone_generator #(
    parameter int PHASE_WIDTH      = mktg_pkg::PHASE_WIDTH_DEF,
    parameter int TABLE_INDEX_BITS = mktg_pkg::TABLE_INDEX_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_sample,
    output logic [2:0]  m_status,
    output logic        m_busy_res
);
    import mktg_pkg::*;

    logic [15:0]            unit_samples_reg;
    logic [31:0]            phase_step_reg;
    logic [PHASE_WIDTH-1:0] phase_reg, phase_next;
    logic [PHASE_WIDTH-1:0] phase_sum;
    logic [7:0]             sine_idx;
    logic [7:0]             sample_next;
    logic                   accept;
    keyer_res_t             kres;

    logic                   m_valid_reg;
    logic [7:0]             m_sample_reg;
    logic [2:0]             m_status_reg;
    logic                   m_busy_res_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_samples_reg <= UNIT_SAMPLES_RST;
            phase_step_reg   <= PHASE_STEP_RST;
        end else if (cfg_wr_en) begin
            if (cfg_wr_index == CFG_UNIT_SAMPLES) begin
                unit_samples_reg <= cfg_wr_data[15:0];
            end else if (cfg_wr_index == CFG_PHASE_STEP) begin
                phase_step_reg <= cfg_wr_data;
            end
        end
    end

    mktg_keyer u_keyer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .command      (s_command),
        .char_code    (s_char_code),
        .unit_samples (unit_samples_reg),
        .res          (kres)
    );

    // Phase advance before the lookup
    assign phase_sum = phase_reg + phase_step_reg[PHASE_WIDTH-1:0];

    // Top table-index bits mapped onto the 256-entry table
    generate
        if (TABLE_INDEX_BITS >= 8) begin : g_idx_wide
            assign sine_idx = phase_sum[PHASE_WIDTH-1 -: 8];
        end else begin : g_idx_narrow
            assign sine_idx = {phase_sum[PHASE_WIDTH-1 -: TABLE_INDEX_BITS],
                               {(8 - TABLE_INDEX_BITS){1'b0}}};
        end
    endgenerate

    // Phase update and sample select
    always_comb begin
        phase_next  = phase_reg;
        sample_next = SILENCE;
        if (accept) begin
            if (s_command == CMD_START) begin
                phase_next = '0;
            end else if (kres.keyed) begin
                phase_next  = phase_sum;
                sample_next = sine_lookup(sine_idx);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
        end else begin
            phase_reg <= phase_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_sample_reg   <= sample_next;
            m_status_reg   <= kres.status;
            m_busy_res_reg <= kres.busy;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_sample   = m_sample_reg;
    assign m_status   = m_status_reg;
    assign m_busy_res = m_busy_res_reg;

`ifndef ASSERT_OFF
    // start clears the phase and reports start taken
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command == CMD_START) |=>
            (phase_reg == '0 && m_status_reg == ST_START))
        else $error("start did not clear phase");
    // only ticks carry tone
    a_non_tick_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_command != CMD_TICK) |=> (m_sample_reg == SILENCE))
        else $error("non-tick result not silent");
    // phase moves only on a keyed tick or a start
    a_phase_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(phase_reg))
        else $error("phase changed without transfer");
`endif

endmodule

[dv/morse_keyer_tone_generator_tb.sv]
// Self-checking testbench for the Morse keyer tone generator: directed table, then random traffic.
`timescale 1ns / 1ps

module morse_keyer_tone_generator_tb;
    import mktg_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         HOLD_CYCLES  = 150;
    localparam int         HOLD_AT      = 600;

    typedef struct packed {
        logic [7:0] sample;
        logic [2:0] status;
        logic       busy;
    } tone_result_t;

    typedef struct packed {
        logic [1:0]   cmd;
        logic [7:0]   ch;
        logic         typed;
        tone_result_t res;
    } stim_row_t;

    // Directed rows; a typed result is checked as written, the rest use the predictor
    localparam stim_row_t DIRECTED [25] = '{
        '{CMD_TICK,   8'h00, 1'b1, '{SILENCE, ST_IDLE_TICK, 1'b0}},
        '{CMD_UNUSED, 8'hFF, 1'b1, '{SILENCE, ST_IGNORED,   1'b0}},
        '{CMD_CHAR,   8'h00, 1'b1, '{SILENCE, ST_IGNORED,   1'b0}},
        '{CMD_CHAR,   8'hFF, 1'b1, '{SILENCE, ST_IGNORED,   1'b0}},
        '{CMD_CHAR,   8'h45, 1'b1, '{SILENCE, ST_CHAR,      1'b1}},
        '{CMD_CHAR,   8'h61, 1'b1, '{SILENCE, ST_REJECT,    1'b1}},
        '{CMD_TICK,   8'h00, 1'b0, '0},
        '{CMD_TICK,   8'hFF, 1'b0, '0},
        '{CMD_TICK,   8'h00, 1'b0, '0},
        '{CMD_TICK,   8'hFF, 1'b0, '0},
        '{CMD_TICK,   8'h00, 1'b1, '{SILENCE, ST_IDLE_TICK, 1'b0}},
        '{CMD_CHAR,   8'h7A, 1'b1, '{SILENCE, ST_CHAR,      1'b1}},
        '{CMD_START,  8'h00, 1'b1, '{SILENCE, ST_START,     1'b1}},
        '{CMD_TICK,   8'h00, 1'b0, '0},
        '{CMD_TICK,   8'h00, 1'b0, '0},
        '{CMD_TICK,   8'h00, 1'b0, '0},
        '{CMD_CHAR,   8'h20, 1'b1, '{SILENCE, ST_CHAR,      1'b1}},
        '{CMD_START,  8'hFF, 1'b1, '{SILENCE, ST_START,     1'b1}},
        '{CMD_CHAR,   8'h30, 1'b1, '{SILENCE, ST_REJECT,    1'b1}},
        '{CMD_TICK,   8'h00, 1'b0, '0},
        '{CMD_TICK,   8'h00, 1'b0, '0},
        '{CMD_TICK,   8'h00, 1'b0, '0},
        '{CMD_CHAR,   8'h39, 1'b1, '{SILENCE, ST_CHAR,      1'b1}},
        '{CMD_TICK,   8'h00, 1'b0, '0},
        '{CMD_START,  8'h00, 1'b1, '{SILENCE, ST_START,     1'b1}}
    };

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_index;
    logic [31:0] cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_command;
    logic [7:0]  s_char_code;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_sample;
    logic [2:0]  m_status;
    logic        m_busy_res;

    // Keyer state as predicted from the accepted transfers
    logic [15:0] cfg_unit;
    logic [31:0] cfg_step;
    logic [31:0] key_phase;
    logic [4:0]  key_dashes;
    logic [2:0]  key_count;
    logic [2:0]  key_index;
    logic [2:0]  key_units;
    logic [15:0] key_samples;
    stage_t      key_stage;

    tone_result_t pending_results [$];
    int error_count   = 0;
    int results_seen  = 0;
    int stalled_cycles = 0;
    int sent_count    = 0;

    morse_keyer_tone_generator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_char_code (s_char_code),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sample    (m_sample),
        .m_status    (m_status),
        .m_busy_res  (m_busy_res)
    );

    always #5 aclk = ~aclk;

    // A unit of zero samples still lasts one sample
    function automatic logic [15:0] unit_len();
        return (cfg_unit == 16'd0) ? 16'd1 : cfg_unit;
    endfunction

    function automatic void enter_stage(input stage_t stage, input logic [2:0] units);
        key_stage   = stage;
        key_units   = units;
        key_samples = unit_len();
    endfunction

    function automatic void begin_element();
        enter_stage(STAGE_TONE, key_dashes[key_index] ? 3'd3 : 3'd1);
    endfunction

    // Next result (sample, status, busy) of the keyer for one command
    function automatic tone_result_t keyer_step(input logic [1:0] cmd, input logic [7:0] ch);
        tone_result_t r;
        int           idx;
        logic [1:0]   quad;
        logic [5:0]   frac;
        logic [7:0]   code;
        r.sample = SILENCE;
        r.status = ST_IGNORED;
        idx      = -1;
        case (cmd)
            CMD_START: begin
                key_phase  = '0;
                key_dashes = '0;
                key_count  = '0;
                key_index  = '0;
                enter_stage(STAGE_SILENT, 3'd3);
                r.status = ST_START;
            end
            CMD_CHAR: begin
                if (key_stage != STAGE_IDLE) begin
                    r.status = ST_REJECT;
                end else if (ch == ASCII_SPACE) begin
                    enter_stage(STAGE_SILENT, 3'd6);
                    r.status = ST_CHAR;
                end else begin
                    if (ch >= 8'h41 && ch <= 8'h5A) idx = int'(ch) - 'h41;
                    else if (ch >= 8'h61 && ch <= 8'h7A) idx = int'(ch) - 'h61;
                    else if (ch >= 8'h30 && ch <= 8'h39) idx = int'(ch) - 'h30 + 26;
                    if (idx >= 0) begin
                        code       = CODE_TABLE[idx];
                        key_dashes = code[4:0];
                        key_count  = code[7:5];
                        key_index  = '0;
                        begin_element();
                        r.status = ST_CHAR;
                    end
                end
            end
            CMD_TICK: begin
                if (key_stage == STAGE_IDLE) begin
                    r.status = ST_IDLE_TICK;
                end else begin
                    r.status = ST_BUSY_TICK;
                    if (key_stage == STAGE_TONE) begin
                        // phase advances first, sine folded from the quarter wave
                        key_phase = key_phase + cfg_step;
                        quad = key_phase[31:30];
                        frac = key_phase[29:24];
                        case (quad)
                            2'd0: r.sample = SINE_QUARTER[frac];
                            2'd1: r.sample = SINE_QUARTER[64 - int'(frac)];
                            2'd2: r.sample = 8'd255 - SINE_QUARTER[frac];
                            default: r.sample = (frac == 6'd0) ? 8'd1 :
                                                8'd255 - SINE_QUARTER[64 - int'(frac)];
                        endcase
                    end
                    if (key_samples > 16'd1) begin
                        key_samples = key_samples - 16'd1;
                    end else if (key_units > 3'd1) begin
                        key_units   = key_units - 3'd1;
                        key_samples = unit_len();
                    end else if (key_stage == STAGE_TONE) begin
                        enter_stage(STAGE_GAP, 3'd1);
                    end else if (key_stage == STAGE_GAP) begin
                        key_index = key_index + 3'd1;
                        if (key_index < key_count) begin_element();
                        else enter_stage(STAGE_SILENT, 3'd2);
                    end else begin
                        key_stage   = STAGE_IDLE;
                        key_units   = '0;
                        key_samples = '0;
                    end
                end
            end
            default: ;
        endcase
        r.busy = (key_stage != STAGE_IDLE);
        return r;
    endfunction

    // Offer one item, wait for its transfer, queue its expected result
    task automatic drive_item(input logic [1:0] cmd, input logic [7:0] ch,
                              input logic typed, input tone_result_t typed_res,
                              output tone_result_t predicted);
        int gap;
        gap = ((sent_count % 50) < 12) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_char_code <= ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = keyer_step(cmd, ch);
        pending_results.push_back(typed ? typed_res : predicted);
        sent_count++;
        @(negedge aclk);
    endtask

    // Let every expected sample arrive before touching the registers
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [15:0] unit, input logic [31:0] step);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= CFG_UNIT_SAMPLES;
        cfg_wr_data  <= {16'd0, unit};
        @(negedge aclk);
        cfg_wr_index <= CFG_PHASE_STEP;
        cfg_wr_data  <= step;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_unit = unit;
        cfg_step = step;
    endtask

    // Mostly well-formed keying: characters when idle, ticks while busy, some noise
    task automatic run_phase(input logic [15:0] unit, input logic [31:0] step, input int count);
        int           useful;
        int           r;
        int           k;
        logic [1:0]   cmd;
        logic [7:0]   ch;
        tone_result_t got;
        useful = 0;
        drain();
        set_config(unit, step);
        drive_item(CMD_START, 8'($urandom), 1'b0, '0, got);
        while (useful < count) begin
            r   = $urandom_range(0, 99);
            ch  = 8'($urandom);
            cmd = CMD_TICK;
            if (key_stage == STAGE_IDLE) begin
                if (r < 10) cmd = CMD_START;
                else if (r < 18) cmd = CMD_CHAR;
                else if (r < 24) cmd = CMD_TICK;
                else if (r < 27) cmd = CMD_UNUSED;
                else if (r < 35) begin
                    cmd = CMD_CHAR;
                    ch  = ASCII_SPACE;
                end else begin
                    cmd = CMD_CHAR;
                    k   = $urandom_range(0, 35);
                    if (k < 26) ch = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(k);
                    else ch = 8'h30 + 8'(k - 26);
                end
            end else begin
                if (r < 2) cmd = CMD_START;
                else if (r < 5) cmd = CMD_CHAR;
                else if (r < 6) cmd = CMD_UNUSED;
            end
            drive_item(cmd, ch, 1'b0, '0, got);
            if (got.status != ST_IGNORED) useful++;
        end
    endtask

    // Stimulus and end of run
    initial begin
        tone_result_t got;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_index = CFG_UNIT_SAMPLES;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_command    = CMD_TICK;
        s_char_code  = '0;
        cfg_unit     = UNIT_SAMPLES_RST;
        cfg_step     = PHASE_STEP_RST;
        key_phase    = '0;
        key_dashes   = '0;
        key_count    = '0;
        key_index    = '0;
        key_units    = '0;
        key_samples  = '0;
        key_stage    = STAGE_IDLE;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // zero-length unit and full-scale phase step for the directed table
        set_config(16'd0, 32'hFFFF_FFFF);
        for (int i = 0; i < 25; i++) begin
            drive_item(DIRECTED[i].cmd, DIRECTED[i].ch, DIRECTED[i].typed,
                       DIRECTED[i].res, got);
        end

        run_phase(16'd1,            32'd0,         250);
        run_phase(16'd2,            32'h8000_0000, 250);
        run_phase(UNIT_SAMPLES_RST, PHASE_STEP_RST, 40);
        run_phase(16'd57600,        $urandom,      30);
        run_phase(16'd3,            $urandom,      300);
        run_phase(16'd0,            $urandom,      200);
        run_phase(16'd4,            32'hFFFF_FFFF, 250);
        run_phase(16'd1,            $urandom,      300);
        run_phase(16'd5,            $urandom,      300);

        drain();
        repeat (16) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Result side: random hold-off, one long stall, compare on each transfer
    initial begin
        int           gap;
        bit           held_off;
        tone_result_t exp_res;
        tone_result_t got_res;
        held_off = 1'b0;
        m_ready  = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            gap = ((results_seen % 64) < 16) ? 0 : $urandom_range(0, 11);
            if (!held_off && results_seen >= HOLD_AT) begin
                gap      = HOLD_CYCLES;
                held_off = 1'b1;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            results_seen++;
            got_res = '{m_sample, m_status, m_busy_res};
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected transfer: sample %0d status %0d busy %0d",
                             m_sample, m_status, m_busy_res);
            end else begin
                exp_res = pending_results.pop_front();
                if (got_res !== exp_res) begin
                    error_count++;
                    // fields shown as sample/status/busy
                    if (error_count <= 10)
                        $display("result %0d mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 results_seen, exp_res.sample, exp_res.status, exp_res.busy,
                                 got_res.sample, got_res.status, got_res.busy);
                end
            end
            @(negedge aclk);
        end
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stalled_cycles <= 0;
            end else if (stalled_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                stalled_cycles <= stalled_cycles + 1;
            end
        end
    end

endmodule

[morse_keyer_tone_generator.f]
rtl/mktg_pkg.sv
rtl/mktg_keyer.sv
rtl/morse_keyer_tone_generator.sv
dv/morse_keyer_tone_generator_tb.sv
